// ===== sv/assert_macros.svh =====
// Assertion macros used by the radio mode sequencer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted.
`define RMS_ASSERT(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

// Clocked check with no reset qualifier.
`define RMS_ASSERT_ALWAYS(label, clk_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

// ===== sv/rms_pkg.sv =====
// Types, codes and constants of the radio mode sequencer.
package rms_pkg;

    typedef logic [1:0]  cmd_t;
    typedef logic [4:0]  sel_t;
    typedef logic [31:0] word_t;
    typedef logic [3:0]  mode_t;
    typedef logic [7:0]  time_t;
    typedef logic [8:0]  evmask_t;
    typedef logic [10:0] inten_t;
    typedef logic [0:0]  cfg_idx_t;

    // Commands
    localparam cmd_t CMD_WRITE = 2'd0;
    localparam cmd_t CMD_READ  = 2'd1;
    localparam cmd_t CMD_TICK  = 2'd2;

    // Register selectors
    localparam sel_t SEL_TXEN      = 5'd0;
    localparam sel_t SEL_RXEN      = 5'd1;
    localparam sel_t SEL_START     = 5'd2;
    localparam sel_t SEL_DISABLE   = 5'd4;
    localparam sel_t SEL_TASK_LAST = 5'd6;
    localparam sel_t SEL_EV_FIRST  = 5'd7;
    localparam sel_t SEL_EV_LAST   = 5'd15;
    localparam sel_t SEL_SHORTS    = 5'd16;
    localparam sel_t SEL_INTEN     = 5'd17;
    localparam sel_t SEL_INTENSET  = 5'd18;
    localparam sel_t SEL_INTENCLR  = 5'd19;
    localparam sel_t SEL_MODE      = 5'd20;

    // Modes
    localparam mode_t MODE_OFF    = 4'd0;
    localparam mode_t MODE_RXRU   = 4'd1;
    localparam mode_t MODE_RXIDLE = 4'd2;
    localparam mode_t MODE_RX     = 4'd3;
    localparam mode_t MODE_RXDIS  = 4'd4;
    localparam mode_t MODE_TXRU   = 4'd9;
    localparam mode_t MODE_TXIDLE = 4'd10;
    localparam mode_t MODE_TX     = 4'd11;
    localparam mode_t MODE_TXDIS  = 4'd12;

    // Event bit positions
    localparam int EV_READY    = 0;
    localparam int EV_ADDRESS  = 1;
    localparam int EV_PAYLOAD  = 2;
    localparam int EV_END      = 3;
    localparam int EV_DISABLED = 4;

    // Shortcut bit positions
    localparam int SC_READY_START   = 0;
    localparam int SC_END_DISABLE   = 1;
    localparam int SC_DISABLED_TXEN = 2;
    localparam int SC_DISABLED_RXEN = 3;
    localparam int SC_END_START     = 5;

    // Interrupt enable bit of the last event
    localparam int IE_BCMATCH = 10;

    // Timing register indexes and reset values
    localparam cfg_idx_t CFG_RAMP   = 1'd0;
    localparam cfg_idx_t CFG_PACKET = 1'd1;
    localparam time_t RAMP_RESET    = 8'd10;
    localparam time_t PACKET_RESET  = 8'd100;

    // Architectural state of the sequencer
    typedef struct packed {
        mode_t   mode;
        time_t   countdown;
        logic    armed;
        evmask_t flags;
        evmask_t shorts;
        inten_t  inten;
    } state_t;

    // Result of one transaction
    typedef struct packed {
        word_t   read_data;
        logic    irq_level;
        evmask_t events_fired;
        mode_t   radio_mode;
    } result_t;

endpackage

// ===== sv/rms_if.sv =====
// Valid/ready channel interfaces of the radio mode sequencer.
interface rms_in_if;
    logic           valid;
    logic           ready;
    rms_pkg::cmd_t  cmd;
    rms_pkg::sel_t  reg_sel;
    rms_pkg::word_t wdata;

    modport source (output valid, output cmd, output reg_sel, output wdata, input ready);
    modport sink   (input valid, input cmd, input reg_sel, input wdata, output ready);
endinterface

interface rms_out_if;
    logic             valid;
    logic             ready;
    rms_pkg::word_t   read_data;
    logic             irq_level;
    rms_pkg::evmask_t events_fired;
    rms_pkg::mode_t   radio_mode;

    modport source (output valid, output read_data, output irq_level,
                    output events_fired, output radio_mode, input ready);
    modport sink   (input valid, input read_data, input irq_level,
                    input events_fired, input radio_mode, output ready);
endinterface

// ===== sv/rms_step.sv =====
// Next-state and result logic for one sequencer transaction.
module rms_step
(
    input  rms_pkg::state_t  cur,
    input  rms_pkg::cmd_t    cmd,
    input  rms_pkg::sel_t    sel,
    input  rms_pkg::word_t   wdata,
    input  rms_pkg::time_t   ramp_time,
    input  rms_pkg::time_t   packet_time,
    output rms_pkg::state_t  nxt,
    output rms_pkg::result_t res
);

    rms_pkg::mode_t   m;
    rms_pkg::time_t   cd;
    logic             arm;
    rms_pkg::evmask_t flg;
    rms_pkg::evmask_t sh;
    rms_pkg::inten_t  ie;
    rms_pkg::evmask_t fired;
    rms_pkg::word_t   rd;
    rms_pkg::evmask_t en_map;
    logic [3:0]       ev_idx;
    logic             nonzero;

    assign nonzero = (wdata != '0);
    assign ev_idx  = 4'(sel - rms_pkg::SEL_EV_FIRST);

    always_comb
    begin
        m     = cur.mode;
        cd    = cur.countdown;
        arm   = cur.armed;
        flg   = cur.flags;
        sh    = cur.shorts;
        ie    = cur.inten;
        fired = '0;
        rd    = '0;

        unique case (cmd)
            rms_pkg::CMD_WRITE:
            begin
                if (sel <= rms_pkg::SEL_TASK_LAST)
                begin
                    // task trigger; only nonzero writes start it
                    if (nonzero)
                    begin
                        unique case (sel)
                            rms_pkg::SEL_TXEN:
                            begin
                                m   = rms_pkg::MODE_TXRU;
                                cd  = ramp_time;
                                arm = 1'b1;
                            end
                            rms_pkg::SEL_RXEN:
                            begin
                                m   = rms_pkg::MODE_RXRU;
                                cd  = ramp_time;
                                arm = 1'b1;
                            end
                            rms_pkg::SEL_START:
                            begin
                                cd  = ramp_time;
                                arm = 1'b1;
                            end
                            rms_pkg::SEL_DISABLE:
                            begin
                                if (m == rms_pkg::MODE_TXIDLE)
                                    m = rms_pkg::MODE_TXDIS;
                                else if (m == rms_pkg::MODE_RXIDLE)
                                    m = rms_pkg::MODE_RXDIS;
                                cd  = ramp_time;
                                arm = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                else if (sel <= rms_pkg::SEL_EV_LAST)
                begin
                    flg[ev_idx] = nonzero;
                end
                else
                begin
                    unique case (sel)
                        rms_pkg::SEL_SHORTS:   sh = wdata[8:0];
                        rms_pkg::SEL_INTEN:    ie = wdata[10:0];
                        rms_pkg::SEL_INTENSET: ie = ie | wdata[10:0];
                        rms_pkg::SEL_INTENCLR: ie = ie & ~wdata[10:0];
                        default: ;
                    endcase
                end
            end

            rms_pkg::CMD_READ:
            begin
                unique case (sel) inside
                    [rms_pkg::SEL_EV_FIRST:rms_pkg::SEL_EV_LAST]:
                        rd = {31'd0, cur.flags[ev_idx]};
                    rms_pkg::SEL_SHORTS:
                        rd = {23'd0, cur.shorts};
                    rms_pkg::SEL_INTEN, rms_pkg::SEL_INTENSET, rms_pkg::SEL_INTENCLR:
                        rd = {21'd0, cur.inten};
                    rms_pkg::SEL_MODE:
                        rd = {28'd0, cur.mode};
                    default:
                        rd = '0;
                endcase
            end

            rms_pkg::CMD_TICK:
            begin
                if (arm)
                begin
                    if (cd <= 8'd1)
                    begin
                        // expiry: disarm, then advance the mode
                        arm = 1'b0;
                        cd  = '0;
                        unique case (m) inside
                            rms_pkg::MODE_TXRU, rms_pkg::MODE_RXRU:
                            begin
                                m = (m == rms_pkg::MODE_TXRU) ? rms_pkg::MODE_TXIDLE
                                                              : rms_pkg::MODE_RXIDLE;
                                fired[rms_pkg::EV_READY] = 1'b1;
                                if (sh[rms_pkg::SC_READY_START])
                                begin
                                    cd  = ramp_time;
                                    arm = 1'b1;
                                end
                            end
                            rms_pkg::MODE_TXIDLE, rms_pkg::MODE_RXIDLE:
                            begin
                                m   = (m == rms_pkg::MODE_TXIDLE) ? rms_pkg::MODE_TX
                                                                  : rms_pkg::MODE_RX;
                                cd  = packet_time;
                                arm = 1'b1;
                            end
                            rms_pkg::MODE_TX, rms_pkg::MODE_RX:
                            begin
                                fired[rms_pkg::EV_ADDRESS] = 1'b1;
                                fired[rms_pkg::EV_PAYLOAD] = 1'b1;
                                fired[rms_pkg::EV_END]     = 1'b1;
                                m = (m == rms_pkg::MODE_TX) ? rms_pkg::MODE_TXIDLE
                                                            : rms_pkg::MODE_RXIDLE;
                                // END shortcuts: disable first, then start
                                if (sh[rms_pkg::SC_END_DISABLE])
                                begin
                                    m   = (m == rms_pkg::MODE_TXIDLE) ? rms_pkg::MODE_TXDIS
                                                                      : rms_pkg::MODE_RXDIS;
                                    cd  = ramp_time;
                                    arm = 1'b1;
                                end
                                if (sh[rms_pkg::SC_END_START])
                                begin
                                    cd  = ramp_time;
                                    arm = 1'b1;
                                end
                            end
                            rms_pkg::MODE_TXDIS, rms_pkg::MODE_RXDIS:
                            begin
                                m = rms_pkg::MODE_OFF;
                                fired[rms_pkg::EV_DISABLED] = 1'b1;
                                if (sh[rms_pkg::SC_DISABLED_TXEN])
                                begin
                                    m   = rms_pkg::MODE_TXRU;
                                    cd  = ramp_time;
                                    arm = 1'b1;
                                end
                                if (sh[rms_pkg::SC_DISABLED_RXEN])
                                begin
                                    m   = rms_pkg::MODE_RXRU;
                                    cd  = ramp_time;
                                    arm = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                        flg = flg | fired;
                    end
                    else
                    begin
                        cd = cd - 8'd1;
                    end
                end
            end

            default: ;
        endcase
    end

    // interrupt: enable bits 0..7 map to events 0..7, bit 10 to the last event
    assign en_map = {ie[rms_pkg::IE_BCMATCH], ie[7:0]};

    assign nxt.mode      = m;
    assign nxt.countdown = cd;
    assign nxt.armed     = arm;
    assign nxt.flags     = flg;
    assign nxt.shorts    = sh;
    assign nxt.inten     = ie;

    assign res.read_data    = rd;
    assign res.irq_level    = |(flg & en_map);
    assign res.events_fired = fired;
    assign res.radio_mode   = m;

endmodule

// ===== sv/radio_mode_sequencer_unit.sv =====
// Top level of the radio mode sequencer: input register, state update, result register.
//
// The sequencer accepts one transaction (bus write, bus read or microsecond tick) per
// clock and returns one result per transaction. A transaction is captured in an input
// register; once the result register is free or being drained, the mode, timer, event
// flag and enable state are updated by combinational logic and the result is loaded
// into the output register. Throughput is one transaction per cycle; it drops only
// while the output side withholds ready. The user must write ramp_time and packet_time
// through the plain write port only while idle; the block itself does not enforce this.
`include "assert_macros.svh"

module radio_mode_sequencer_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  rms_pkg::cfg_idx_t   wr_index,
    input  rms_pkg::time_t      wr_data,
    rms_in_if.sink              in_chan,
    rms_out_if.source           out_chan
);

    rms_pkg::state_t  state_reg;
    rms_pkg::state_t  state_next;
    rms_pkg::result_t result_next;
    rms_pkg::result_t result_reg;
    rms_pkg::time_t   ramp_reg;
    rms_pkg::time_t   packet_reg;

    logic             s1_valid_reg;
    rms_pkg::cmd_t    s1_cmd_reg;
    rms_pkg::sel_t    s1_sel_reg;
    rms_pkg::word_t   s1_wdata_reg;
    logic             out_valid_reg;
    logic             advance;

    // stage moves when the result register is free or being drained
    assign advance       = s1_valid_reg && (!out_valid_reg || out_chan.ready);
    assign in_chan.ready = !s1_valid_reg || advance;

    // timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_reg   <= rms_pkg::RAMP_RESET;
            packet_reg <= rms_pkg::PACKET_RESET;
        end
        else if (wr_en)
        begin
            if (wr_index == rms_pkg::CFG_RAMP)
                ramp_reg <= wr_data;
            else
                packet_reg <= wr_data;
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_chan.ready)
            s1_valid_reg <= in_chan.valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_chan.valid && in_chan.ready)
        begin
            s1_cmd_reg   <= in_chan.cmd;
            s1_sel_reg   <= in_chan.reg_sel;
            s1_wdata_reg <= in_chan.wdata;
        end
    end

    rms_step u_step
    (
        .cur         (state_reg),
        .cmd         (s1_cmd_reg),
        .sel         (s1_sel_reg),
        .wdata       (s1_wdata_reg),
        .ramp_time   (ramp_reg),
        .packet_time (packet_reg),
        .nxt         (state_next),
        .res         (result_next)
    );

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_chan.ready)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign out_chan.valid        = out_valid_reg;
    assign out_chan.read_data    = result_reg.read_data;
    assign out_chan.irq_level    = result_reg.irq_level;
    assign out_chan.events_fired = result_reg.events_fired;
    assign out_chan.radio_mode   = result_reg.radio_mode;

    // checks
    `RMS_ASSERT(a_fire_tick_only, clk, rst_n,
        advance && (s1_cmd_reg != rms_pkg::CMD_TICK) |=> (result_reg.events_fired == '0),
        "events fired by a non-tick transaction")
    `RMS_ASSERT(a_fired_flagged, clk, rst_n,
        advance |=> ((result_reg.events_fired & state_reg.flags) == result_reg.events_fired),
        "fired event not recorded in the flags")
    `RMS_ASSERT(a_countdown_dec, clk, rst_n,
        advance && (s1_cmd_reg == rms_pkg::CMD_TICK) && state_reg.armed
            && (state_reg.countdown > 8'd1)
            |=> (state_reg.countdown == 8'($past(state_reg.countdown) - 8'd1)),
        "timer did not count down on a tick")
    `RMS_ASSERT(a_mode_matches, clk, rst_n,
        advance |=> (result_reg.radio_mode == state_reg.mode),
        "reported mode differs from the mode register")

endmodule
